/* sv/iirdf1_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_pkg
// shared widths, register indexes and types for the direct form I iir filter
// ----------------------------------------------------------------------------
package iirdf1_pkg;

    // tap counts
    localparam int FF_TAPS    = 4;
    localparam int FB_TAPS    = 3;
    localparam int HIST_DEPTH = 3;

    // data widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int FRAC_BITS = 14;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int FF_SUM_W  = PROD_W + 2;
    localparam int ACC_W     = PROD_W + 4;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_3 = 3'd6;

    // unity gain in q3.14
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_BITS);

    // rounding and saturation limits on the accumulator
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN    = -ACC_W'(1 << (SAMPLE_W - 1));

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [FF_TAPS-1:0][COEF_W-1:0] ff;
        logic [FB_TAPS-1:0][COEF_W-1:0] fb;   // fb index 0 is tap 1
    } coef_set_t;

    typedef struct packed {
        logic                       start;
        logic signed [FF_SUM_W-1:0] ff_sum;
    } q_entry_t;

endpackage

/* sv/iirdf1_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_front
// input history and feedforward products, sums pushed into the queue
// ----------------------------------------------------------------------------
module iirdf1_front
    import iirdf1_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic                       in_start,
    input  coef_set_t                  coefs,
    output logic                       push_valid,
    input  logic                       push_ready,
    output q_entry_t                   push_entry
);

    logic signed [SAMPLE_W-1:0] xh_reg   [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] xh_next  [HIST_DEPTH];
    logic signed [PROD_W-1:0]   prod_reg [FF_TAPS];
    logic signed [PROD_W-1:0]   prod_next[FF_TAPS];
    logic signed [SAMPLE_W-1:0] taps     [FF_TAPS];
    logic                       start_reg;
    logic                       a_valid_reg;
    logic                       a_valid_next;
    logic                       accept;
    logic signed [FF_SUM_W-1:0] sum;

    assign in_ready = !a_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    // tap values, history cleared on pulse start
    always_comb
    begin
        for (int k = 0; k < FF_TAPS; k++)
        begin
            if (k == 0)
                taps[k] = in_sample;
            else if (in_start)
                taps[k] = '0;
            else
                taps[k] = xh_reg[k-1];
        end
        for (int k = 0; k < FF_TAPS; k++)
        begin
            if (k < FF_TAPS)
                prod_next[k] = $signed(coefs.ff[k]) * taps[k];
            else
                prod_next[k] = '0;
        end
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            if (!accept)
                xh_next[k] = xh_reg[k];
            else if (k == 0)
                xh_next[k] = in_sample;
            else if (in_start)
                xh_next[k] = '0;
            else
                xh_next[k] = xh_reg[k-1];
        end
    end

    always_comb
    begin
        if (accept)
            a_valid_next = 1'b1;
        else if (push_ready)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++)
                xh_reg[k] <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            xh_reg      <= xh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg  <= prod_next;
            start_reg <= in_start;
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < FF_TAPS; k++)
            sum = sum + FF_SUM_W'(prod_reg[k]);
    end

    assign push_valid        = a_valid_reg;
    assign push_entry.start  = start_reg;
    assign push_entry.ff_sum = sum;

endmodule

/* sv/iirdf1_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_queue
// short fifo of feedforward sums between front and back
// ----------------------------------------------------------------------------
module iirdf1_queue
    import iirdf1_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_entry,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_entry
);

    q_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* sv/iirdf1_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf1_back
// feedback sum, rounding, saturation and the output register
// ----------------------------------------------------------------------------
module iirdf1_back
    import iirdf1_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  q_entry_t                   pop_entry,
    input  coef_set_t                  coefs,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_filtered,
    output logic                       out_saturated
);

    logic signed [SAMPLE_W-1:0] yh_reg  [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] yh_next [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] ytap    [HIST_DEPTH];
    logic signed [PROD_W-1:0]   fb_prod [HIST_DEPTH];
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [SAMPLE_W-1:0] y;
    logic                       sat;
    logic                       fire;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       sat_reg;

    assign pop_ready = !m_valid_reg || out_ready;
    assign fire      = pop_valid && pop_ready;

    always_comb
    begin
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            ytap[k] = pop_entry.start ? '0 : yh_reg[k];
            if (k < FB_TAPS)
                fb_prod[k] = $signed(coefs.fb[k]) * ytap[k];
            else
                fb_prod[k] = '0;
        end
        acc = ACC_W'(pop_entry.ff_sum);
        for (int k = 0; k < HIST_DEPTH; k++)
            acc = acc - ACC_W'(fb_prod[k]);
        // round half up, then floor
        rounded = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (rounded > OUT_MAX)
        begin
            y   = OUT_MAX[SAMPLE_W-1:0];
            sat = 1'b1;
        end
        else if (rounded < OUT_MIN)
        begin
            y   = OUT_MIN[SAMPLE_W-1:0];
            sat = 1'b1;
        end
        else
        begin
            y   = rounded[SAMPLE_W-1:0];
            sat = 1'b0;
        end
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            if (!fire)
                yh_next[k] = yh_reg[k];
            else if (k == 0)
                yh_next[k] = y;
            else
                yh_next[k] = ytap[k-1];
        end
    end

    always_comb
    begin
        if (fire)
            m_valid_next = 1'b1;
        else if (out_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++)
                yh_reg[k] <= '0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            yh_reg      <= yh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            y_reg   <= y;
            sat_reg <= sat;
        end
    end

    assign out_valid     = m_valid_reg;
    assign out_filtered  = y_reg;
    assign out_saturated = sat_reg;

endmodule

/* sv/iir_direct_form_one_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter_unit
// direct form i iir filter, four feedforward and three feedback taps
// ----------------------------------------------------------------------------
// Each signed 16-bit sample on the slave stream gives one filtered sample on
// the master stream. Coefficients are signed q3.14 and set through the cfg
// write port (indexes 0..3 feedforward taps 0..3, 4..6 feedback taps 1..3,
// other indexes ignored); ff_coef_0 resets to 1.0 and all others to 0, so the
// filter passes samples unchanged out of reset. The full-precision sum is
// rounded to nearest with ties toward plus infinity, then clipped to 16 bits
// with the saturated flag set; the clipped value is what feeds back. A request
// with tuser high clears both histories before its sample is used. The block
// takes one request per clock unless the queue fills. The front registers
// the four feedforward products and pushes their sum into a two-entry queue;
// the back pops one entry per clock unless stalled and closes the feedback
// loop combinationally (three parallel multiplies, sum, round, clip), which
// sets the clock limit. Results pass front registers, the queue and the
// output register. Write coefficients only while no request is in flight.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter_unit
    import iirdf1_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input sample stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // [15:0] sample
    input  logic                 s_tuser,    // [0] pulse_start
    // filtered sample stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,    // [15:0] filtered
    output logic                 m_tuser,    // [0] saturated
    // coefficient write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    coef_set_t coefs_reg;
    coef_set_t coefs_next;
    logic      push_valid;
    logic      push_ready;
    q_entry_t  push_entry;
    logic      pop_valid;
    logic      pop_ready;
    q_entry_t  pop_entry;
    logic signed [SAMPLE_W-1:0] filtered;

    // coefficient registers, always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FF_COEF_0: coefs_next.ff[0] = cfg_data;
                REG_FF_COEF_1: coefs_next.ff[1] = cfg_data;
                REG_FF_COEF_2: coefs_next.ff[2] = cfg_data;
                REG_FF_COEF_3: coefs_next.ff[3] = cfg_data;
                REG_FB_COEF_1: coefs_next.fb[0] = cfg_data;
                REG_FB_COEF_2: coefs_next.fb[1] = cfg_data;
                REG_FB_COEF_3: coefs_next.fb[2] = cfg_data;
                default:       coefs_next = coefs_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // unity gain on the current input, every other tap zero
            coefs_reg <= {{(COEF_W * (FF_TAPS - 1)){1'b0}}, COEF_ONE,
                          {(COEF_W * FB_TAPS){1'b0}}};
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    // front: input history and feedforward products
    iirdf1_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  ($signed(s_tdata[SAMPLE_W-1:0])),
        .in_start   (s_tuser),
        .coefs      (coefs_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // decouples the front pipeline from the feedback loop
    iirdf1_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // back: feedback loop and output register
    iirdf1_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .coefs         (coefs_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_filtered  (filtered),
        .out_saturated (m_tuser)
    );

    assign m_tdata = filtered;

endmodule
